### rtl/cmbi_pkg.sv
// Shared constants, codes and types for the cartridge mapper block.
// No dependencies; every other file imports this package.
`default_nettype none
package cmbi_pkg;

	localparam int unsigned FM_CLOCK_DIVIDE = 36;
	localparam int unsigned FM_DIV_W = 6;

	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned TGT_W    = 3;
	localparam int unsigned MADDR_W  = 21;
	localparam int unsigned FMK_W    = 2;
	localparam int unsigned CHRK_W   = 2;
	localparam int unsigned PRESC_W  = 10;

	localparam logic [FUNC_W-1:0] FUNC_CPU_RD = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_CPU_WR = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PPU_RD = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_PPU_WR = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd4;

	localparam logic [TGT_W-1:0] TGT_OPEN    = 3'd0;
	localparam logic [TGT_W-1:0] TGT_PRG_RAM = 3'd1;
	localparam logic [TGT_W-1:0] TGT_PRG_ROM = 3'd2;
	localparam logic [TGT_W-1:0] TGT_NT      = 3'd3;
	localparam logic [TGT_W-1:0] TGT_CHR_ROM = 3'd4;
	localparam logic [TGT_W-1:0] TGT_CHR_RAM = 3'd5;
	localparam logic [TGT_W-1:0] TGT_NONE    = 3'd6;

	localparam logic [FMK_W-1:0] FMK_NONE = 2'd0;
	localparam logic [FMK_W-1:0] FMK_ADDR = 2'd1;
	localparam logic [FMK_W-1:0] FMK_DATA = 2'd2;

	localparam logic [CHRK_W-1:0] CHRK_NONE = 2'd0;
	localparam logic [CHRK_W-1:0] CHRK_ROM  = 2'd1;
	localparam logic [CHRK_W-1:0] CHRK_RAM  = 2'd2;

	localparam logic [ADDR_W-1:0] ADDR_PRG_RAM_LO = 16'h6000;
	localparam logic [ADDR_W-1:0] ADDR_ROM_LO     = 16'h8000;
	localparam logic [ADDR_W-1:0] ADDR_PRG0       = 16'h8000;
	localparam logic [ADDR_W-1:0] ADDR_PRG1       = 16'h8010;
	localparam logic [ADDR_W-1:0] ADDR_PRG2       = 16'h9000;
	localparam logic [ADDR_W-1:0] ADDR_FM_ADDR    = 16'h9010;
	localparam logic [ADDR_W-1:0] ADDR_FM_DATA    = 16'h9030;
	localparam logic [ADDR_W-1:0] ADDR_CHR0       = 16'ha000;
	localparam logic [ADDR_W-1:0] ADDR_CHR1       = 16'ha010;
	localparam logic [ADDR_W-1:0] ADDR_CHR2       = 16'hb000;
	localparam logic [ADDR_W-1:0] ADDR_CHR3       = 16'hb010;
	localparam logic [ADDR_W-1:0] ADDR_CHR4       = 16'hc000;
	localparam logic [ADDR_W-1:0] ADDR_CHR5       = 16'hc010;
	localparam logic [ADDR_W-1:0] ADDR_CHR6       = 16'hd000;
	localparam logic [ADDR_W-1:0] ADDR_CHR7       = 16'hd010;
	localparam logic [ADDR_W-1:0] ADDR_MISC       = 16'he000;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_LATCH  = 16'he010;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_CTRL   = 16'hf000;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_ACK    = 16'hf010;

	localparam logic [DATA_W-1:0] TOP_PRG_BANK = 8'hff;
	localparam logic [DATA_W-1:0] IRQ_WRAP     = 8'hff;
	localparam logic signed [PRESC_W-1:0] PRESC_RELOAD = 10'sd341;
	localparam logic signed [PRESC_W-1:0] PRESC_STEP   = 10'sd3;

	localparam int unsigned NUM_PRG = 3;
	localparam int unsigned NUM_CHR = 8;

	typedef struct packed {
		logic              tick;
		logic              wr_latch;
		logic              wr_ctrl;
		logic              wr_ack;
		logic [DATA_W-1:0] data;
	} irq_cmd_t;

endpackage
`default_nettype wire

### rtl/cmbi_if.sv
// Handshake channel interfaces for the mapper: request beats and result beats.
// Depends on cmbi_pkg for field widths.
`default_nettype none
interface cmbi_req_if;
	import cmbi_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] data;
	modport source (output valid, output func, output address, output data, input ready);
	modport sink (input valid, input func, input address, input data, output ready);
endinterface

interface cmbi_rsp_if;
	import cmbi_pkg::*;
	logic               valid;
	logic               ready;
	logic [TGT_W-1:0]   target;
	logic [MADDR_W-1:0] mem_address;
	logic               irq_line;
	logic [FMK_W-1:0]   fm_write_kind;
	logic [DATA_W-1:0]  fm_data;
	logic               fm_reset;
	logic               fm_enabled;
	logic               fm_tick;
	logic               ram_writable;
	modport source (output valid, output target, output mem_address, output irq_line,
		output fm_write_kind, output fm_data, output fm_reset, output fm_enabled,
		output fm_tick, output ram_writable, input ready);
	modport sink (input valid, input target, input mem_address, input irq_line,
		input fm_write_kind, input fm_data, input fm_reset, input fm_enabled,
		input fm_tick, input ram_writable, output ready);
endinterface
`default_nettype wire

### rtl/cmbi_irq.sv
// IRQ counter: latch, control, scanline prescaler and pending flag.
// Depends on cmbi_pkg; driven by one command struct per advancing beat.
`default_nettype none
module cmbi_irq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmbi_pkg::irq_cmd_t cmd,
	output logic                    pending_nxt
);
	import cmbi_pkg::*;

	logic [DATA_W-1:0]         reload_q, reload_n;
	logic                      cyc_mode_q, cyc_mode_n;
	logic                      running_q, running_n;
	logic                      ack_en_q, ack_en_n;
	logic [DATA_W-1:0]         count_q, count_n;
	logic signed [PRESC_W-1:0] presc_q, presc_n;
	logic                      pending_q, pending_n;
	logic signed [PRESC_W-1:0] presc_dec;
	logic                      presc_le0;
	logic                      clk_cnt;

	assign presc_dec = presc_q - PRESC_STEP;
	assign presc_le0 = presc_dec[PRESC_W-1] || (presc_dec == '0);

	always_comb begin
		reload_n   = reload_q;
		cyc_mode_n = cyc_mode_q;
		running_n  = running_q;
		ack_en_n   = ack_en_q;
		count_n    = count_q;
		presc_n    = presc_q;
		pending_n  = pending_q;
		clk_cnt    = 1'b0;
		if (cmd.wr_latch) begin
			reload_n = cmd.data;
		end
		if (cmd.wr_ctrl) begin
			ack_en_n   = cmd.data[0];
			running_n  = cmd.data[1];
			cyc_mode_n = cmd.data[2];
			if (cmd.data[1]) begin
				count_n = reload_q;
				presc_n = PRESC_RELOAD;
			end
			pending_n = 1'b0;
		end
		if (cmd.wr_ack) begin
			running_n = ack_en_q;
			pending_n = 1'b0;
		end
		if (cmd.tick && running_q) begin
			if (!cyc_mode_q) begin
				presc_n = presc_le0 ? presc_dec + PRESC_RELOAD : presc_dec;
				clk_cnt = presc_le0;
			end else begin
				clk_cnt = 1'b1;
			end
		end
		if (clk_cnt) begin
			if (count_q == IRQ_WRAP) begin
				count_n   = reload_q;
				pending_n = 1'b1;
			end else begin
				count_n = count_q + 8'd1;
			end
		end
	end

	assign pending_nxt = pending_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q   <= '0;
			cyc_mode_q <= 1'b0;
			running_q  <= 1'b0;
			ack_en_q   <= 1'b0;
			count_q    <= '0;
			presc_q    <= '0;
			pending_q  <= 1'b0;
		end else begin
			reload_q   <= reload_n;
			cyc_mode_q <= cyc_mode_n;
			running_q  <= running_n;
			ack_en_q   <= ack_en_n;
			count_q    <= count_n;
			presc_q    <= presc_n;
			pending_q  <= pending_n;
		end
	end

endmodule
`default_nettype wire

### rtl/cartridge_mapper_banking_irq_unit.sv
// Top level of the cartridge mapper: banking, address mapping, FM port pass-through.
// Depends on cmbi_pkg, cmbi_if and cmbi_irq.
//
//  channel | dir | handshake      | payload
//  req     | in  | valid / ready  | func, address, data
//  rsp     | out | valid / ready  | target, mem_address, irq_line, fm_*, ram_writable
//  cfg     | in  | cfg_we         | cfg_data = chr_kind
//
// One beat per cycle unless the result stalls; path: input register, result register.
// State changes as a beat moves from the input register into the result register.
// A stalled result holds its register; the input register still takes a beat if the
// result is leaving. Reset: all mapper registers to power-on values, chr_kind ROM.
`default_nettype none
module cartridge_mapper_banking_irq_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	cmbi_req_if.sink                     req,
	cmbi_rsp_if.source                   rsp,
	input  wire logic                    cfg_we,
	input  wire logic [cmbi_pkg::CHRK_W-1:0] cfg_data
);
	import cmbi_pkg::*;

	logic              vld_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;
	logic              adv;

	logic [CHRK_W-1:0]   chr_kind_q;
	logic [DATA_W-1:0]   prg_bank_q [NUM_PRG];
	logic [DATA_W-1:0]   chr_bank_q [NUM_CHR];
	logic [1:0]          mirror_q;
	logic                fm_dis_q;
	logic                ram_we_q;
	logic [FM_DIV_W-1:0] fm_div_q;

	logic [1:0]          mirror_n;
	logic                fm_dis_n;
	logic                ram_we_n;
	logic [FM_DIV_W-1:0] fm_div_n;
	logic [FM_DIV_W-1:0] fm_div_inc;

	logic [TGT_W-1:0]   tgt;
	logic [MADDR_W-1:0] maddr;
	logic [FMK_W-1:0]   fmk;
	logic [DATA_W-1:0]  fmd;
	logic               fmr;
	logic               fmt;
	logic [13:0]        pa;
	logic [DATA_W-1:0]  prg_sel;
	logic [10:0]        nt_a;
	logic [17:0]        chr_a;
	logic               is_wr;

	irq_cmd_t irq_cmd;
	logic     irq_pend_nxt;

	logic               rsp_vld_q;
	logic [TGT_W-1:0]   rsp_tgt_q;
	logic [MADDR_W-1:0] rsp_maddr_q;
	logic               rsp_irq_q;
	logic [FMK_W-1:0]   rsp_fmk_q;
	logic [DATA_W-1:0]  rsp_fmd_q;
	logic               rsp_fmr_q;
	logic               rsp_fme_q;
	logic               rsp_fmt_q;
	logic               rsp_ramw_q;

	assign adv       = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1 <= req.func;
			addr_s1 <= req.address;
			data_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_kind_q <= CHRK_ROM;
		end else if (cfg_we) begin
			chr_kind_q <= cfg_data;
		end
	end

	// address mapping
	assign pa    = addr_s1[13:0];
	assign chr_a = {chr_bank_q[pa[12:10]], pa[9:0]};
	assign is_wr = (func_s1 == FUNC_CPU_WR);

	always_comb begin
		case (addr_s1[15:13])
			3'b100:  prg_sel = prg_bank_q[0];
			3'b101:  prg_sel = prg_bank_q[1];
			3'b110:  prg_sel = prg_bank_q[2];
			default: prg_sel = TOP_PRG_BANK;
		endcase
	end

	always_comb begin
		case (mirror_q)
			2'd0:    nt_a = {pa[10], pa[9:0]};
			2'd1:    nt_a = {pa[11], pa[9:0]};
			2'd2:    nt_a = {1'b0, pa[9:0]};
			default: nt_a = {1'b1, pa[9:0]};
		endcase
	end

	always_comb begin
		tgt   = TGT_NONE;
		maddr = '0;
		case (func_s1)
			FUNC_CPU_RD: begin
				if (addr_s1 < ADDR_PRG_RAM_LO) begin
					tgt = TGT_OPEN;
				end else if (addr_s1 < ADDR_ROM_LO) begin
					tgt   = TGT_PRG_RAM;
					maddr = {8'd0, addr_s1[12:0]};
				end else begin
					tgt   = TGT_PRG_ROM;
					maddr = {prg_sel, addr_s1[12:0]};
				end
			end
			FUNC_CPU_WR: begin
				if (addr_s1 >= ADDR_PRG_RAM_LO && addr_s1 < ADDR_ROM_LO) begin
					tgt   = TGT_PRG_RAM;
					maddr = {8'd0, addr_s1[12:0]};
				end
			end
			FUNC_PPU_RD, FUNC_PPU_WR: begin
				if (pa[13]) begin
					tgt   = TGT_NT;
					maddr = {10'd0, nt_a};
				end else if (chr_kind_q == CHRK_RAM) begin
					tgt   = TGT_CHR_RAM;
					maddr = {3'd0, chr_a};
				end else if (chr_kind_q == CHRK_ROM && func_s1 == FUNC_PPU_RD) begin
					tgt   = TGT_CHR_ROM;
					maddr = {3'd0, chr_a};
				end
			end
			default: begin
				tgt = TGT_NONE;
			end
		endcase
	end

	// mapper register writes
	always_comb begin
		mirror_n = mirror_q;
		fm_dis_n = fm_dis_q;
		ram_we_n = ram_we_q;
		fmk      = FMK_NONE;
		fmd      = '0;
		fmr      = 1'b0;
		irq_cmd  = '0;
		irq_cmd.data = data_s1;
		if (adv && is_wr) begin
			case (addr_s1)
				ADDR_FM_ADDR: begin
					fmk = FMK_ADDR;
					fmd = data_s1;
				end
				ADDR_FM_DATA: begin
					fmk = FMK_DATA;
					fmd = data_s1;
				end
				ADDR_MISC: begin
					fmr      = fm_dis_q && !data_s1[6];
					mirror_n = data_s1[1:0];
					fm_dis_n = data_s1[6];
					ram_we_n = data_s1[7];
				end
				ADDR_IRQ_LATCH: irq_cmd.wr_latch = 1'b1;
				ADDR_IRQ_CTRL:  irq_cmd.wr_ctrl  = 1'b1;
				ADDR_IRQ_ACK:   irq_cmd.wr_ack   = 1'b1;
				default: ;
			endcase
		end
		irq_cmd.tick = adv && (func_s1 == FUNC_TICK);
	end

	// FM clock divider
	assign fm_div_inc = fm_div_q + 6'd1;
	always_comb begin
		fm_div_n = fm_div_q;
		fmt      = 1'b0;
		if (irq_cmd.tick) begin
			if (fm_div_inc == FM_DIV_W'(FM_CLOCK_DIVIDE)) begin
				fm_div_n = '0;
				fmt      = 1'b1;
			end else begin
				fm_div_n = fm_div_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRG; i++) prg_bank_q[i] <= '0;
			for (int i = 0; i < NUM_CHR; i++) chr_bank_q[i] <= '0;
			mirror_q <= '0;
			fm_dis_q <= 1'b1;
			ram_we_q <= 1'b1;
			fm_div_q <= '0;
		end else begin
			mirror_q <= mirror_n;
			fm_dis_q <= fm_dis_n;
			ram_we_q <= ram_we_n;
			fm_div_q <= fm_div_n;
			if (adv && is_wr) begin
				case (addr_s1)
					ADDR_PRG0: prg_bank_q[0] <= data_s1;
					ADDR_PRG1: prg_bank_q[1] <= data_s1;
					ADDR_PRG2: prg_bank_q[2] <= data_s1;
					ADDR_CHR0: chr_bank_q[0] <= data_s1;
					ADDR_CHR1: chr_bank_q[1] <= data_s1;
					ADDR_CHR2: chr_bank_q[2] <= data_s1;
					ADDR_CHR3: chr_bank_q[3] <= data_s1;
					ADDR_CHR4: chr_bank_q[4] <= data_s1;
					ADDR_CHR5: chr_bank_q[5] <= data_s1;
					ADDR_CHR6: chr_bank_q[6] <= data_s1;
					ADDR_CHR7: chr_bank_q[7] <= data_s1;
					default: ;
				endcase
			end
		end
	end

	cmbi_irq u_irq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (irq_cmd),
		.pending_nxt (irq_pend_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_tgt_q   <= tgt;
			rsp_maddr_q <= maddr;
			rsp_irq_q   <= irq_pend_nxt;
			rsp_fmk_q   <= fmk;
			rsp_fmd_q   <= fmd;
			rsp_fmr_q   <= fmr;
			rsp_fme_q   <= !fm_dis_n;
			rsp_fmt_q   <= fmt;
			rsp_ramw_q  <= ram_we_n;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.target        = rsp_tgt_q;
	assign rsp.mem_address   = rsp_maddr_q;
	assign rsp.irq_line      = rsp_irq_q;
	assign rsp.fm_write_kind = rsp_fmk_q;
	assign rsp.fm_data       = rsp_fmd_q;
	assign rsp.fm_reset      = rsp_fmr_q;
	assign rsp.fm_enabled    = rsp_fme_q;
	assign rsp.fm_tick       = rsp_fmt_q;
	assign rsp.ram_writable  = rsp_ramw_q;

	a_irq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_wr && (addr_s1 == ADDR_IRQ_CTRL || addr_s1 == ADDR_IRQ_ACK)
		|=> !rsp_irq_q)
		else $error("irq pending not cleared by control write");

	a_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv && func_s1 != FUNC_TICK |=> !rsp_fmt_q)
		else $error("fm tick without cycle tick");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		fm_div_q < FM_DIV_W'(FM_CLOCK_DIVIDE))
		else $error("fm divider out of range");

	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && (rsp_tgt_q == TGT_OPEN || rsp_tgt_q == TGT_NONE)
		|-> rsp_maddr_q == '0)
		else $error("nonzero address with no target");

endmodule
`default_nettype wire

### verif/cartridge_mapper_banking_irq_unit_checker.sv
`timescale 1ns / 1ps
// Result checker for the cartridge mapper: watches request, result and config ports,
// keeps its own copy of the mapper state and compares each result beat in order.
// Depends on cmbi_pkg and cmbi_if.
module cartridge_mapper_banking_irq_unit_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	cmbi_req_if                              req,
	cmbi_rsp_if                              rsp,
	input  wire logic                        cfg_we,
	input  wire logic [cmbi_pkg::CHRK_W-1:0] cfg_data,
	output int unsigned                      mismatches,
	output int unsigned                      outstanding
);
	import cmbi_pkg::*;

	localparam logic [1:0] MIR_VERTICAL   = 2'd0;
	localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
	localparam logic [1:0] MIR_ONE_LOW    = 2'd2;
	localparam logic [1:0] MIR_ONE_HIGH   = 2'd3;
	localparam int unsigned REPORT_MAX    = 10;

	typedef struct packed {
		logic [TGT_W-1:0]   target;
		logic [MADDR_W-1:0] mem_address;
		logic               irq_line;
		logic [FMK_W-1:0]   fm_write_kind;
		logic [DATA_W-1:0]  fm_data;
		logic               fm_reset;
		logic               fm_enabled;
		logic               fm_tick;
		logic               ram_writable;
	} mapper_result_t;

	logic [CHRK_W-1:0]         chr_fitted;
	logic [DATA_W-1:0]         prg_sel [NUM_PRG];
	logic [DATA_W-1:0]         chr_sel [NUM_CHR];
	logic [1:0]                mirroring;
	logic                      fm_off;
	logic                      wram_we;
	logic [DATA_W-1:0]         irq_latch;
	logic                      irq_every_cycle;
	logic                      irq_on;
	logic                      irq_ack_on;
	logic [DATA_W-1:0]         irq_counter;
	logic signed [PRESC_W-1:0] irq_scaler;
	logic                      irq_flag;
	logic [FM_DIV_W-1:0]       fm_phase;

	mapper_result_t expected_results [$];

	function automatic void clock_irq_counter();
		if (irq_counter == IRQ_WRAP) begin
			irq_counter = irq_latch;
			irq_flag = 1'b1;
		end else begin
			irq_counter = irq_counter + 1'b1;
		end
	endfunction

	function automatic mapper_result_t apply_access(logic [FUNC_W-1:0] f,
			logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		mapper_result_t r;
		logic [13:0] pa;
		logic [DATA_W-1:0] bank;
		logic nt_hi;
		r = '0;
		r.target = TGT_NONE;
		pa = a[13:0];
		case (f)
			FUNC_CPU_RD: begin
				if (a < ADDR_PRG_RAM_LO) begin
					r.target = TGT_OPEN;
				end else if (a < ADDR_ROM_LO) begin
					r.target = TGT_PRG_RAM;
					r.mem_address = MADDR_W'(a[12:0]);
				end else begin
					case (a[14:13])
						2'b00: bank = prg_sel[0];
						2'b01: bank = prg_sel[1];
						2'b10: bank = prg_sel[2];
						default: bank = TOP_PRG_BANK;
					endcase
					r.target = TGT_PRG_ROM;
					r.mem_address = {bank, a[12:0]};
				end
			end
			FUNC_CPU_WR: begin
				if (a >= ADDR_PRG_RAM_LO && a < ADDR_ROM_LO) begin
					r.target = TGT_PRG_RAM;
					r.mem_address = MADDR_W'(a[12:0]);
				end else if (a >= ADDR_ROM_LO) begin
					case (a)
						ADDR_PRG0: prg_sel[0] = d;
						ADDR_PRG1: prg_sel[1] = d;
						ADDR_PRG2: prg_sel[2] = d;
						ADDR_FM_ADDR: begin
							r.fm_write_kind = FMK_ADDR;
							r.fm_data = d;
						end
						ADDR_FM_DATA: begin
							r.fm_write_kind = FMK_DATA;
							r.fm_data = d;
						end
						ADDR_CHR0: chr_sel[0] = d;
						ADDR_CHR1: chr_sel[1] = d;
						ADDR_CHR2: chr_sel[2] = d;
						ADDR_CHR3: chr_sel[3] = d;
						ADDR_CHR4: chr_sel[4] = d;
						ADDR_CHR5: chr_sel[5] = d;
						ADDR_CHR6: chr_sel[6] = d;
						ADDR_CHR7: chr_sel[7] = d;
						ADDR_MISC: begin
							// re-enabling the FM chip resets it
							r.fm_reset = fm_off && !d[6];
							mirroring = d[1:0];
							fm_off = d[6];
							wram_we = d[7];
						end
						ADDR_IRQ_LATCH: irq_latch = d;
						ADDR_IRQ_CTRL: begin
							irq_ack_on = d[0];
							irq_on = d[1];
							irq_every_cycle = d[2];
							if (irq_on) begin
								irq_counter = irq_latch;
								irq_scaler = PRESC_RELOAD;
							end
							irq_flag = 1'b0;
						end
						ADDR_IRQ_ACK: begin
							irq_on = irq_ack_on;
							irq_flag = 1'b0;
						end
						default: ;
					endcase
				end
			end
			FUNC_PPU_RD, FUNC_PPU_WR: begin
				if (pa[13]) begin
					case (mirroring)
						MIR_VERTICAL: nt_hi = pa[10];
						MIR_HORIZONTAL: nt_hi = pa[11];
						MIR_ONE_LOW: nt_hi = 1'b0;
						default: nt_hi = 1'b1;
					endcase
					r.target = TGT_NT;
					r.mem_address = MADDR_W'({nt_hi, pa[9:0]});
				end else if (chr_fitted == CHRK_RAM) begin
					r.target = TGT_CHR_RAM;
					r.mem_address = MADDR_W'({chr_sel[pa[12:10]], pa[9:0]});
				end else if (chr_fitted == CHRK_ROM && f == FUNC_PPU_RD) begin
					r.target = TGT_CHR_ROM;
					r.mem_address = MADDR_W'({chr_sel[pa[12:10]], pa[9:0]});
				end
			end
			FUNC_TICK: begin
				if (irq_on) begin
					if (!irq_every_cycle) begin
						irq_scaler = irq_scaler - PRESC_STEP;
						if (irq_scaler <= 0) begin
							irq_scaler = irq_scaler + PRESC_RELOAD;
							clock_irq_counter();
						end
					end else begin
						clock_irq_counter();
					end
				end
				fm_phase = fm_phase + 1'b1;
				if (fm_phase == FM_DIV_W'(FM_CLOCK_DIVIDE)) begin
					fm_phase = '0;
					r.fm_tick = 1'b1;
				end
			end
			default: ;
		endcase
		r.irq_line = irq_flag;
		r.fm_enabled = !fm_off;
		r.ram_writable = wram_we;
		return r;
	endfunction

	function automatic string describe(mapper_result_t r);
		return $sformatf("tgt=%0d maddr=%h irq=%b fmk=%0d fmd=%h fmr=%b fme=%b fmt=%b ramw=%b",
			r.target, r.mem_address, r.irq_line, r.fm_write_kind, r.fm_data,
			r.fm_reset, r.fm_enabled, r.fm_tick, r.ram_writable);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mapper_result_t got;
		mapper_result_t want;
		if (!arst_n) begin
			chr_fitted = CHRK_ROM;
			for (int i = 0; i < NUM_PRG; i++) prg_sel[i] = '0;
			for (int i = 0; i < NUM_CHR; i++) chr_sel[i] = '0;
			mirroring = MIR_VERTICAL;
			fm_off = 1'b1;
			wram_we = 1'b1;
			irq_latch = '0;
			irq_every_cycle = 1'b0;
			irq_on = 1'b0;
			irq_ack_on = 1'b0;
			irq_counter = '0;
			irq_scaler = '0;
			irq_flag = 1'b0;
			fm_phase = '0;
			expected_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) chr_fitted = cfg_data;
			if (req.valid && req.ready)
				expected_results.push_back(apply_access(req.func, req.address, req.data));
			if (rsp.valid && rsp.ready) begin
				got.target = rsp.target;
				got.mem_address = rsp.mem_address;
				got.irq_line = rsp.irq_line;
				got.fm_write_kind = rsp.fm_write_kind;
				got.fm_data = rsp.fm_data;
				got.fm_reset = rsp.fm_reset;
				got.fm_enabled = rsp.fm_enabled;
				got.fm_tick = rsp.fm_tick;
				got.ram_writable = rsp.ram_writable;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result beat with nothing expected: %s", $time,
							describe(got));
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("%0t: result mismatch", $time);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

### verif/cartridge_mapper_banking_irq_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the cartridge mapper: clock, reset, request beats, result stalls
// and the verdict. Depends on cmbi_pkg, cmbi_if, the mapper RTL and the checker.
module cartridge_mapper_banking_irq_unit_tb;
	import cmbi_pkg::*;

	localparam logic [CHRK_W-1:0] CHRK_UNFITTED = 2'd3;
	localparam int unsigned PHASE_BEATS = 170;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CHRK_W-1:0] cfg_data;
	int unsigned       mismatches;
	int unsigned       outstanding;
	int unsigned       beats_sent = 0;
	int unsigned       burst_left = 0;

	cmbi_req_if req ();
	cmbi_rsp_if rsp ();

	cartridge_mapper_banking_irq_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	cartridge_mapper_banking_irq_unit_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	function automatic logic [ADDR_W-1:0] reg_port(int unsigned slot);
		case (slot)
			0: return ADDR_PRG0;
			1: return ADDR_PRG1;
			2: return ADDR_PRG2;
			3: return ADDR_FM_ADDR;
			4: return ADDR_FM_DATA;
			5: return ADDR_CHR0;
			6: return ADDR_CHR1;
			7: return ADDR_CHR2;
			8: return ADDR_CHR3;
			9: return ADDR_CHR4;
			10: return ADDR_CHR5;
			11: return ADDR_CHR6;
			12: return ADDR_CHR7;
			13: return ADDR_MISC;
			14: return ADDR_IRQ_LATCH;
			15: return ADDR_IRQ_CTRL;
			default: return ADDR_IRQ_ACK;
		endcase
	endfunction

	task automatic push_access(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		req.valid <= 1'b1;
		req.func <= f;
		req.address <= a;
		req.data <= d;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	task automatic wait_quiet();
		req.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side stalls
	initial begin
		int unsigned mode;
		int unsigned left;
		logic [15:0] bits;
		mode = 0;
		left = 0;
		bits = '0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
				bits = 16'($urandom);
			end else begin
				left--;
			end
			case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= bits[left % 16];
				2: rsp.ready <= ($urandom_range(0, 3) != 0);
				default: rsp.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		logic [CHRK_W-1:0] kind;
		logic [DATA_W-1:0] ctrl;
		logic [DATA_W-1:0] latch;
		int unsigned phase_end;
		int unsigned sel;
		int unsigned run;
		int unsigned slot;
		req.valid <= 1'b0;
		req.func <= FUNC_CPU_RD;
		req.address <= '0;
		req.data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= CHRK_ROM;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_access(FUNC_CPU_RD, 16'h0000, 8'h00);
		push_access(FUNC_CPU_RD, 16'h5fff, 8'hff);
		push_access(FUNC_CPU_WR, 16'h5fff, 8'hff);
		push_access(FUNC_CPU_WR, ADDR_PRG_RAM_LO, 8'ha5);
		push_access(FUNC_CPU_RD, 16'h7fff, 8'h00);
		push_access(FUNC_CPU_WR, ADDR_PRG0, 8'hff);
		push_access(FUNC_CPU_WR, ADDR_PRG1, 8'h80);
		push_access(FUNC_CPU_WR, ADDR_PRG2, 8'h01);
		push_access(FUNC_CPU_RD, 16'h9fff, 8'h00);
		push_access(FUNC_CPU_RD, 16'ha000, 8'h00);
		push_access(FUNC_CPU_RD, 16'hdfff, 8'h00);
		push_access(FUNC_CPU_RD, 16'hffff, 8'h00);
		push_access(FUNC_CPU_WR, ADDR_FM_ADDR, 8'h55);
		push_access(FUNC_CPU_WR, ADDR_FM_DATA, 8'haa);
		push_access(FUNC_CPU_WR, ADDR_MISC, 8'h43);
		push_access(FUNC_PPU_RD, 16'h2fff, 8'h00);
		push_access(FUNC_CPU_WR, ADDR_MISC, 8'h81);
		push_access(FUNC_CPU_WR, ADDR_CHR7, 8'hff);
		push_access(FUNC_PPU_RD, 16'h1fff, 8'h00);
		push_access(FUNC_PPU_WR, 16'h1c00, 8'h3c);
		push_access(FUNC_CPU_WR, 16'h8001, 8'h12);
		push_access(FUNC_W'(int'(FUNC_TICK) + 1), 16'hffff, 8'hff);
		push_access(FUNC_W'((1 << FUNC_W) - 1), 16'h0000, 8'h00);
		// counter overflow in cycle mode, then acknowledge with restart
		push_access(FUNC_CPU_WR, ADDR_IRQ_LATCH, 8'hfe);
		push_access(FUNC_CPU_WR, ADDR_IRQ_CTRL, 8'h07);
		push_access(FUNC_TICK, 16'h0000, 8'h00);
		push_access(FUNC_TICK, 16'h0000, 8'h00);
		push_access(FUNC_CPU_WR, ADDR_IRQ_ACK, 8'h00);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: kind = CHRK_RAM;
				1: kind = CHRK_NONE;
				2: kind = CHRK_UNFITTED;
				3: kind = CHRK_ROM;
				default: kind = CHRK_W'($urandom);
			endcase
			wait_quiet();
			cfg_we <= 1'b1;
			cfg_data <= kind;
			@(posedge clk);
			cfg_we <= 1'b0;
			phase_end = beats_sent + PHASE_BEATS;
			while (beats_sent < phase_end) begin
				sel = $urandom_range(0, 99);
				slot = $urandom_range(0, 16);
				if (sel < 25) begin
					push_access(FUNC_CPU_WR, reg_port(slot), DATA_W'($urandom));
				end else if (sel < 30) begin
					// near miss of a register address
					push_access(FUNC_CPU_WR,
						reg_port(slot) ^ ADDR_W'(1 << $urandom_range(0, ADDR_W - 1)),
						DATA_W'($urandom));
				end else if (sel < 45) begin
					push_access(FUNC_CPU_RD, ADDR_W'($urandom), DATA_W'($urandom));
				end else if (sel < 52) begin
					push_access(FUNC_CPU_WR, ADDR_W'($urandom), DATA_W'($urandom));
				end else if (sel < 67) begin
					push_access($urandom_range(0, 1) ? FUNC_PPU_RD : FUNC_PPU_WR,
						ADDR_W'($urandom), DATA_W'($urandom));
				end else if (sel < 88) begin
					run = $urandom_range(1, 24);
					repeat (run) push_access(FUNC_TICK, ADDR_W'($urandom), DATA_W'($urandom));
				end else if (sel < 96) begin
					push_access(FUNC_W'($urandom_range(int'(FUNC_TICK) + 1, (1 << FUNC_W) - 1)),
						ADDR_W'($urandom), DATA_W'($urandom));
				end else begin
					latch = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom)
						: DATA_W'($urandom_range('hfd, 'hff));
					ctrl = DATA_W'($urandom);
					ctrl[1] = ($urandom_range(0, 4) != 0);
					push_access(FUNC_CPU_WR, ADDR_IRQ_LATCH, latch);
					push_access(FUNC_CPU_WR, ADDR_IRQ_CTRL, ctrl);
					run = ctrl[2] ? $urandom_range(1, 24) : $urandom_range(100, 300);
					repeat (run) begin
						if ($urandom_range(0, 15) == 0)
							push_access(FUNC_PPU_RD, ADDR_W'($urandom), DATA_W'($urandom));
						else
							push_access(FUNC_TICK, ADDR_W'($urandom), DATA_W'($urandom));
					end
					push_access(FUNC_CPU_WR, ADDR_IRQ_ACK, DATA_W'($urandom));
				end
			end
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/cmbi_pkg.sv
rtl/cmbi_if.sv
rtl/cmbi_irq.sv
rtl/cartridge_mapper_banking_irq_unit.sv
verif/cartridge_mapper_banking_irq_unit_checker.sv
verif/cartridge_mapper_banking_irq_unit_tb.sv
